// ===== rtl/vfcm_pkg.sv =====
package vfcm_pkg;

  // Default sizes of the grid and of the material table.
  localparam int MAX_XY_DEF  = 16;
  localparam int MAX_Z_DEF   = 64;
  localparam int NUM_MAT_DEF = 32;

  // Width used for range compares of coordinates and sizes.
  localparam int CMP_W = 10;

  // Field widths.
  localparam int VAL_W  = 7;
  localparam int VCNT_W = 19;
  localparam int VS_W   = 11;
  localparam int PROD_W = 17;
  localparam int APB_AW = 4;

  // Commands.
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_MESH  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Register indexes (byte address bits [3:2]).
  localparam logic [1:0] REG_XY_SIZE    = 2'd0;
  localparam logic [1:0] REG_Z_SIZE     = 2'd1;
  localparam logic [1:0] REG_VOXEL_SIZE = 2'd2;
  localparam logic [1:0] REG_GRASS_EN   = 2'd3;

  // Register reset values.
  localparam logic [4:0]  XY_SIZE_RST    = 5'd16;
  localparam logic [6:0]  Z_SIZE_RST     = 7'd64;
  localparam logic [10:0] VOXEL_SIZE_RST = 11'd100;

  // Face directions, in emission order.
  localparam logic [2:0] DIR_PZ = 3'd0;
  localparam logic [2:0] DIR_NZ = 3'd1;
  localparam logic [2:0] DIR_PY = 3'd2;
  localparam logic [2:0] DIR_NY = 3'd3;
  localparam logic [2:0] DIR_PX = 3'd4;
  localparam logic [2:0] DIR_NX = 3'd5;
  localparam int         NUM_DIRS = 6;

  // Cell codes and visibility thresholds.
  localparam logic signed [VAL_W-1:0] VAL_GRASS       = -7'sd1;
  localparam logic signed [VAL_W-1:0] OPAQUE_MIN      = 7'sd10;
  localparam logic [VAL_W-1:0]        SEE_THROUGH_MAT = 7'd20;
  localparam logic [VCNT_W-1:0]       VERT_STEP       = 19'd4;

  localparam logic KIND_FACE  = 1'b0;
  localparam logic KIND_GRASS = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OWN,
    S_CNT,
    S_GPOS,
    S_SCAN,
    S_EMIT,
    S_GRASS
  } state_t;

endpackage

// ===== rtl/voxel_face_culling_mesher.sv =====
// Voxel face-culling mesher.
// Requests arrive on the s_axis channel; tuser carries the command. A write
// request stores one cell value, a clear request zeroes all per-material vertex
// counters, and a mesh request produces zero to six face results (or one grass
// instance result) on the m_axis channel, with tlast on the last one. Requests
// that produce nothing give nothing on m_axis.
// Meshing a solid cell holds the input while the sequencer reads the cell,
// reads its material's vertex counter and classifies it, streams six neighbor
// reads through the single read port of the cell store, and emits each visible
// face in turn. One shared multiplier forms the x, y and z positions in turn.
// A grass cell adds a position step and a grass step; any other cell without
// results ends after classification, and one outside the range in use on
// acceptance. s_axis_tready is high only while the sequencer is idle.
// Results leave through an output register, so a stalled receiver holds the
// sequencer only when it has the next result ready; the input side keeps taking
// requests whenever the sequencer is idle.
// rst is synchronous and active high: it restores the register defaults, zeroes
// the vertex counters and drops m_axis_tvalid. The cell store is not cleared;
// every cell must be written before it is meshed. Configuration (APB, pready
// always high) must be written only while idle; the block does not enforce it.
module voxel_face_culling_mesher
  import vfcm_pkg::*;
#(
  parameter int MAX_XY        = MAX_XY_DEF,
  parameter int MAX_Z         = MAX_Z_DEF,
  parameter int NUM_MATERIALS = NUM_MAT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // Configuration port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // Request channel.
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata: cell_x [3:0], cell_y [7:4], cell_z [13:8], cell_value [20:14], zero [23:21]
  input  logic [23:0]       s_axis_tdata,
  // tuser: cmd [1:0]
  input  logic [1:0]        s_axis_tuser,
  // Result channel.
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // tdata: material [4:0], face_dir [7:5], first_vertex [26:8], pos_x [40:27],
  //        pos_y [54:41], pos_z [71:55]
  output logic [71:0]       m_axis_tdata,
  // tuser: kind [0]
  output logic              m_axis_tuser,
  output logic              m_axis_tlast
);

  localparam int XYW = $clog2(MAX_XY);
  localparam int ZW  = $clog2(MAX_Z);
  localparam int AW  = 2 * XYW + ZW;
  localparam int CELL_DEPTH = 1 << AW;
  localparam int MW  = (NUM_MATERIALS > 1) ? $clog2(NUM_MATERIALS) : 1;

  // Request fields.
  logic [1:0]              in_cmd;
  logic [3:0]              in_x;
  logic [3:0]              in_y;
  logic [5:0]              in_z;
  logic signed [VAL_W-1:0] in_val;

  assign in_cmd = s_axis_tuser;
  assign in_x   = s_axis_tdata[3:0];
  assign in_y   = s_axis_tdata[7:4];
  assign in_z   = s_axis_tdata[13:8];
  assign in_val = s_axis_tdata[20:14];

  // Configuration registers.
  logic [4:0]      xy_size;
  logic [6:0]      z_size;
  logic [VS_W-1:0] voxel_size;
  logic            grass_en;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      xy_size    <= XY_SIZE_RST;
      z_size     <= Z_SIZE_RST;
      voxel_size <= VOXEL_SIZE_RST;
      grass_en   <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_XY_SIZE:    xy_size    <= pwdata[4:0];
        REG_Z_SIZE:     z_size     <= pwdata[6:0];
        REG_VOXEL_SIZE: voxel_size <= pwdata[VS_W-1:0];
        REG_GRASS_EN:   grass_en   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_XY_SIZE:    prdata = 32'(xy_size);
      REG_Z_SIZE:     prdata = 32'(z_size);
      REG_VOXEL_SIZE: prdata = 32'(voxel_size);
      REG_GRASS_EN:   prdata = 32'(grass_en);
      default:        prdata = '0;
    endcase
  end

  // Sizes in use are clamped to the store dimensions.
  logic [CMP_W-1:0] eff_xy;
  logic [CMP_W-1:0] eff_z;

  assign eff_xy = (CMP_W'(xy_size) > CMP_W'(MAX_XY)) ? CMP_W'(MAX_XY) : CMP_W'(xy_size);
  assign eff_z  = (CMP_W'(z_size) > CMP_W'(MAX_Z)) ? CMP_W'(MAX_Z) : CMP_W'(z_size);

  // Sequencer state and working registers.
  state_t                  state;
  state_t                  state_next;
  logic [3:0]              x_q;
  logic [3:0]              y_q;
  logic [5:0]              z_q;
  logic signed [VAL_W-1:0] own_q;
  logic [VAL_W-1:0]        mat_q;
  logic [VCNT_W-1:0]       vcount_q;
  logic [13:0]             px_q;
  logic [13:0]             py_q;
  logic [PROD_W-1:0]       pz_q;
  logic [2:0]              scan_d;
  logic [NUM_DIRS-1:0]     vis_q;

  // Vertex counter valid bits: a counter that is not valid reads as zero.
  logic [NUM_MATERIALS-1:0] cnt_vld;

  // Cell store.
  logic                    cell_we;
  logic [AW-1:0]           cell_waddr;
  logic [AW-1:0]           cell_raddr;
  logic [VAL_W-1:0]        cell_rdata;
  logic signed [VAL_W-1:0] cell_val;

  assign cell_val = cell_rdata;

  vfcm_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CELL_DEPTH)
  ) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (in_val),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  // Vertex counter store.
  logic              cnt_we;
  logic [MW-1:0]     cnt_raddr;
  logic [VCNT_W-1:0] cnt_rdata;
  logic [VCNT_W-1:0] cnt_wdata;

  assign cnt_wdata = vcount_q + VERT_STEP;
  assign cnt_raddr = MW'(cell_rdata - 7'd1);

  vfcm_ram #(
    .WIDTH (VCNT_W),
    .DEPTH (NUM_MATERIALS)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (mat_q[MW-1:0]),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  // Request decode.
  logic accept;
  logic wr_in_store;
  logic mesh_in_range;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign wr_in_store = (CMP_W'(in_x) < CMP_W'(MAX_XY)) && (CMP_W'(in_y) < CMP_W'(MAX_XY))
                       && (CMP_W'(in_z) < CMP_W'(MAX_Z));
  assign mesh_in_range = (CMP_W'(in_x) < eff_xy) && (CMP_W'(in_y) < eff_xy)
                         && (CMP_W'(in_z) < eff_z);
  assign cell_waddr = {ZW'(in_z), XYW'(in_y), XYW'(in_x)};

  // Classification of the meshed cell.
  logic solid;
  logic grass;
  logic mat_ok;
  logic see_through;

  assign solid       = own_q > 7'sd0;
  assign grass       = own_q == VAL_GRASS;
  assign mat_ok      = CMP_W'(mat_q) < CMP_W'(NUM_MATERIALS);
  assign see_through = mat_q >= SEE_THROUGH_MAT;

  // Neighbor address for the read issued in this scan step.
  logic [XYW-1:0] nb_x;
  logic [XYW-1:0] nb_y;
  logic [ZW-1:0]  nb_z;

  always_comb begin
    nb_x = XYW'(x_q);
    nb_y = XYW'(y_q);
    nb_z = ZW'(z_q);
    case (scan_d)
      DIR_PZ:  nb_z = ZW'(z_q) + ZW'(1);
      DIR_NZ:  nb_z = ZW'(z_q) - ZW'(1);
      DIR_PY:  nb_y = XYW'(y_q) + XYW'(1);
      DIR_NY:  nb_y = XYW'(y_q) - XYW'(1);
      DIR_PX:  nb_x = XYW'(x_q) + XYW'(1);
      DIR_NX:  nb_x = XYW'(x_q) - XYW'(1);
      default: ;
    endcase
  end

  // Visibility of the face whose neighbor data arrives in this scan step.
  logic [2:0] chk_d;
  logic       out_xy;
  logic       out_z;
  logic       vis_bit;

  assign chk_d = scan_d - 3'd1;

  always_comb begin
    out_xy = 1'b0;
    out_z  = 1'b0;
    case (chk_d)
      DIR_PZ:  out_z  = (CMP_W'(z_q) + CMP_W'(1)) >= eff_z;
      DIR_NZ:  out_z  = (z_q == '0);
      DIR_PY:  out_xy = (CMP_W'(y_q) + CMP_W'(1)) >= eff_xy;
      DIR_NY:  out_xy = (y_q == '0);
      DIR_PX:  out_xy = (CMP_W'(x_q) + CMP_W'(1)) >= eff_xy;
      DIR_NX:  out_xy = (x_q == '0);
      default: ;
    endcase
  end

  // Material 20 and up is always drawn; a neighbor outside x/y shows the face,
  // one outside z hides it.
  assign vis_bit = see_through || out_xy || (!out_z && (cell_val < OPAQUE_MIN));

  // Lowest pending face.
  logic [2:0]          face;
  logic [NUM_DIRS-1:0] vis_rest;

  always_comb begin
    face = DIR_NX;
    for (int i = NUM_DIRS - 1; i >= 0; i--) begin
      if (vis_q[i]) begin
        face = 3'(i);
      end
    end
  end

  assign vis_rest = vis_q & ~(NUM_DIRS'(1) << face);

  // Shared multiplier for the three position products.
  logic [5:0]        mul_a;
  logic [PROD_W-1:0] prod;

  assign prod = PROD_W'(mul_a * voxel_size);

  // Output register.
  logic out_free;
  logic emit_face;
  logic emit_grass;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  // Next state and control.
  always_comb begin
    state_next    = state;
    s_axis_tready = (state == S_IDLE);
    cell_we       = 1'b0;
    cell_raddr    = cell_waddr;
    cnt_we        = 1'b0;
    mul_a         = z_q;
    emit_face     = 1'b0;
    emit_grass    = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cell_we = (in_cmd == CMD_WRITE) && wr_in_store;
          if ((in_cmd == CMD_MESH) && mesh_in_range) begin
            state_next = S_OWN;
          end
        end
      end
      S_OWN: begin
        mul_a      = 6'(x_q);
        state_next = S_CNT;
      end
      S_CNT: begin
        mul_a = 6'(y_q);
        if (solid && mat_ok) begin
          state_next = S_SCAN;
        end else if (grass && grass_en) begin
          state_next = S_GPOS;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_GPOS: begin
        state_next = S_GRASS;
      end
      S_SCAN: begin
        cell_raddr = {nb_z, nb_y, nb_x};
        if (scan_d == 3'(NUM_DIRS)) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (vis_q == '0) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          emit_face = 1'b1;
          cnt_we    = 1'b1;
          if (vis_rest == '0) begin
            state_next = S_IDLE;
          end
        end
      end
      S_GRASS: begin
        if (out_free) begin
          emit_grass = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Counter valid bits are cleared by reset and by a clear request.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_vld <= '0;
    end else if (accept && (in_cmd == CMD_CLEAR)) begin
      cnt_vld <= '0;
    end else if (cnt_we) begin
      cnt_vld[mat_q[MW-1:0]] <= 1'b1;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      x_q <= in_x;
      y_q <= in_y;
      z_q <= in_z;
    end
    case (state)
      S_OWN: begin
        own_q <= cell_val;
        mat_q <= cell_rdata - 7'd1;
        px_q  <= prod[13:0];
      end
      S_CNT: begin
        vcount_q <= (mat_ok && cnt_vld[mat_q[MW-1:0]]) ? cnt_rdata : '0;
        py_q     <= prod[13:0];
        scan_d   <= '0;
        vis_q    <= '0;
      end
      S_GPOS: begin
        pz_q <= prod;
      end
      S_SCAN: begin
        if (scan_d == '0) begin
          pz_q <= prod;
        end else begin
          vis_q[chk_d] <= vis_bit;
        end
        scan_d <= scan_d + 3'd1;
      end
      S_EMIT: begin
        if (emit_face) begin
          vis_q    <= vis_rest;
          vcount_q <= cnt_wdata;
        end
      end
      default: ;
    endcase
  end

  // Result register.
  logic              o_kind;
  logic [4:0]        o_mat;
  logic [2:0]        o_dir;
  logic [VCNT_W-1:0] o_fv;
  logic [13:0]       o_px;
  logic [13:0]       o_py;
  logic [PROD_W-1:0] o_pz;
  logic              o_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit_face || emit_grass) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_face) begin
      o_kind <= KIND_FACE;
      o_mat  <= mat_q[4:0];
      o_dir  <= face;
      o_fv   <= vcount_q;
      o_px   <= px_q;
      o_py   <= py_q;
      o_pz   <= pz_q;
      o_last <= (vis_rest == '0);
    end else if (emit_grass) begin
      // A grass instance sits half a cell lower than the cell origin.
      o_kind <= KIND_GRASS;
      o_mat  <= '0;
      o_dir  <= DIR_PZ;
      o_fv   <= '0;
      o_px   <= px_q;
      o_py   <= py_q;
      o_pz   <= pz_q - PROD_W'(voxel_size[VS_W-1:1]);
      o_last <= 1'b1;
    end
  end

  assign m_axis_tdata = {o_pz, o_py, o_px, o_fv, o_dir, o_mat};
  assign m_axis_tuser = o_kind;
  assign m_axis_tlast = o_last;

endmodule

// ===== rtl/vfcm_ram.sv =====
module vfcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Simple dual-port array with a registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
